// ----- design/ucd_pkg.sv -----
// Shared constants and helpers for the UTF-8 code point decoder.
package ucd_pkg;

    localparam int unsigned CpW  = 21;
    localparam int unsigned LenW = 3;

    localparam logic [7:0] LeadAsciiMax = 8'h7F;
    localparam logic [7:0] Lead2Lo      = 8'hC2;
    localparam logic [7:0] Lead2Hi      = 8'hDF;
    localparam logic [7:0] Lead3Lo      = 8'hE0;
    localparam logic [7:0] Lead3Hi      = 8'hEF;
    localparam logic [7:0] Lead4Lo      = 8'hF0;
    localparam logic [7:0] Lead4Hi      = 8'hF4;
    localparam logic [7:0] ContLo       = 8'h80;
    localparam logic [7:0] ContHi       = 8'hBF;

    localparam logic [CpW-1:0] CpMax   = 21'h10FFFF;
    localparam logic [CpW-1:0] SurrLo  = 21'h00D800;
    localparam logic [CpW-1:0] SurrHi  = 21'h00DFFF;
    localparam logic [CpW-1:0] Min2    = 21'h000080;
    localparam logic [CpW-1:0] Min3    = 21'h000800;
    localparam logic [CpW-1:0] Min4    = 21'h010000;

    localparam logic [LenW-1:0] LenMax = 3'd4;

    function automatic logic is_cont(input logic [7:0] b);
        return (b >= ContLo) && (b <= ContHi);
    endfunction

endpackage

// ----- design/utf8_codepoint_decoder.sv -----
// UTF-8 code point decoder: input register, one decode pass, result register.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  command  | start / busy         | i_byte_0..i_byte_3, i_avail_len
//  result   | o_valid (strobe)     | o_code_point, o_consumed_len
//
// A beat is taken at every edge with start high; busy stays low, so one beat
// per cycle is sustained. Each result passes through the input register and
// the result register around the decode logic. Results are shown for exactly
// one cycle under o_valid; the receiver cannot stall them. Synchronous
// active-low reset clears both valid flags.
module utf8_codepoint_decoder
    import ucd_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  logic [7:0]      i_byte_0,
    input  logic [7:0]      i_byte_1,
    input  logic [7:0]      i_byte_2,
    input  logic [7:0]      i_byte_3,
    input  logic [2:0]      i_avail_len,
    output logic            o_valid,
    output logic [CpW-1:0]  o_code_point,
    output logic [LenW-1:0] o_consumed_len
);

    typedef enum logic [1:0] {
        t_LEAD_ONE,
        t_LEAD_TWO,
        t_LEAD_THREE,
        t_LEAD_FOUR
    } t_lead;

    // Input stage
    logic            r_in_valid;
    logic [7:0]      r_b0, r_b1, r_b2, r_b3;
    logic [2:0]      r_avail;

    // Result stage
    logic            r_out_valid;
    logic [CpW-1:0]  r_code_point;
    logic [LenW-1:0] r_len;

    logic [CpW-1:0]  n_code_point;
    logic [LenW-1:0] n_len;

    logic [2:0]      avail_sat;
    t_lead           lead;
    logic [CpW-1:0]  value;
    logic [CpW-1:0]  min_val;
    logic            form_ok;
    logic            ok;

    // No internal backpressure: every cycle can take a beat.
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
        if (start && !busy) begin
            r_b0    <= i_byte_0;
            r_b1    <= i_byte_1;
            r_b2    <= i_byte_2;
            r_b3    <= i_byte_3;
            r_avail <= i_avail_len;
        end
    end

    always_comb begin
        // Saturate the byte count at four.
        avail_sat = (r_avail > LenMax) ? LenMax : r_avail;

        // Classify the lead byte; bad leads fall to the one-byte class.
        if (r_b0 inside {[Lead2Lo:Lead2Hi]}) begin
            lead = t_LEAD_TWO;
        end else if (r_b0 inside {[Lead3Lo:Lead3Hi]}) begin
            lead = t_LEAD_THREE;
        end else if (r_b0 inside {[Lead4Lo:Lead4Hi]}) begin
            lead = t_LEAD_FOUR;
        end else begin
            lead = t_LEAD_ONE;
        end

        case (lead)
            t_LEAD_TWO: begin
                value   = {10'd0, r_b0[4:0], r_b1[5:0]};
                min_val = Min2;
                form_ok = (avail_sat >= 3'd2) && is_cont(r_b1);
                n_len   = 3'd2;
            end
            t_LEAD_THREE: begin
                value   = {5'd0, r_b0[3:0], r_b1[5:0], r_b2[5:0]};
                min_val = Min3;
                form_ok = (avail_sat >= 3'd3) && is_cont(r_b1) && is_cont(r_b2);
                n_len   = 3'd3;
            end
            t_LEAD_FOUR: begin
                value   = {r_b0[2:0], r_b1[5:0], r_b2[5:0], r_b3[5:0]};
                min_val = Min4;
                form_ok = (avail_sat >= 3'd4) && is_cont(r_b1) && is_cont(r_b2)
                          && is_cont(r_b3);
                n_len   = 3'd4;
            end
            default: begin
                value   = {13'd0, r_b0};
                min_val = '0;
                form_ok = 1'b0;
                n_len   = 3'd1;
            end
        endcase

        // Reject overlong forms, values past the top plane and surrogates.
        ok = form_ok && (value >= min_val) && (value <= CpMax)
             && !((value >= SurrLo) && (value <= SurrHi));

        if (avail_sat == 3'd0) begin
            n_code_point = '0;
            n_len        = 3'd0;
        end else if (r_b0 <= LeadAsciiMax) begin
            n_code_point = {13'd0, r_b0};
            n_len        = 3'd1;
        end else if (ok) begin
            n_code_point = value;
        end else begin
            // Fall back to the lead byte alone.
            n_code_point = {13'd0, r_b0};
            n_len        = 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
        if (r_in_valid) begin
            r_code_point <= n_code_point;
            r_len        <= n_len;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_code_point   = r_code_point;
    assign o_consumed_len = r_len;

`ifndef ASSERT_OFF
    // Every command beat yields a result through the input and result registers.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> ##1 o_valid)
        else $error("result strobe missing two cycles after a command beat");

    // An empty result carries a zero code point.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_consumed_len == 3'd0) |-> (o_code_point == '0))
        else $error("empty result with nonzero code point");

    // A one-byte result is the lead byte itself.
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_consumed_len == 3'd1) |-> (o_code_point[CpW-1:8] == '0))
        else $error("one-byte result wider than a byte");

    // A multibyte result is a valid scalar value.
    a_scalar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_consumed_len >= 3'd2) |->
            (o_code_point >= Min2 && o_code_point <= CpMax
             && (o_code_point < SurrLo || o_code_point > SurrHi)))
        else $error("multibyte result outside the scalar range");

    // Consumed length never exceeds four bytes.
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_consumed_len <= LenMax))
        else $error("consumed length above four");
`endif

endmodule
